/* sv/ctmr_pkg.sv */
// Package with shared constants, types and codes of the channel message reassembler.
package ctmr_pkg;

    localparam int CHANNELS = 16;
    localparam int MAX_LEN  = 64;

    localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LEN_W   = $clog2(MAX_LEN);
    localparam int MEM_AW  = CH_AW + LEN_W;
    localparam int CNT_W   = 7;
    localparam int CH_W    = 4;
    localparam int TAG_W   = 16;
    localparam int BYTE_W  = 8;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    localparam logic [BYTE_W-1:0] CODE_LO = 8'h30;
    localparam logic [BYTE_W-1:0] CODE_HI = 8'h3f;

    localparam logic OP_ARM  = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam logic STATUS_MSG = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic load_in;
        logic commit;
        logic load_err;
        logic rd_issue;
        logic load_byte;
    } t_cmd;

    typedef struct packed {
        logic is_illegal;
        logic done;
        logic out_free;
        logic emit_last;
    } t_sts;

endpackage

/* sv/ctmr_ctrl.sv */
// Controller state machine that sequences item execution and message readout.
module ctmr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  ctmr_pkg::t_sts i_sts,
    output logic          o_s_ready,
    output ctmr_pkg::t_cmd o_cmd
);

    ctmr_pkg::t_state r_state;
    ctmr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctmr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctmr_pkg::ST_IDLE: begin
                if (i_s_valid) begin
                    n_state = ctmr_pkg::ST_EXEC;
                end
            end
            ctmr_pkg::ST_EXEC: begin
                if (i_sts.is_illegal) begin
                    if (i_sts.out_free) begin
                        n_state = ctmr_pkg::ST_IDLE;
                    end
                end else if (i_sts.done) begin
                    n_state = ctmr_pkg::ST_READ;
                end else begin
                    n_state = ctmr_pkg::ST_IDLE;
                end
            end
            ctmr_pkg::ST_READ: begin
                n_state = ctmr_pkg::ST_SEND;
            end
            ctmr_pkg::ST_SEND: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.emit_last ? ctmr_pkg::ST_IDLE : ctmr_pkg::ST_READ;
                end
            end
            default: begin
                n_state = ctmr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_ready = 1'b0;
        o_cmd     = '0;
        unique case (r_state)
            ctmr_pkg::ST_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.load_in = i_s_valid;
            end
            ctmr_pkg::ST_EXEC: begin
                if (i_sts.is_illegal) begin
                    o_cmd.load_err = i_sts.out_free;
                end else begin
                    o_cmd.commit = 1'b1;
                end
            end
            ctmr_pkg::ST_READ: begin
                o_cmd.rd_issue = 1'b1;
            end
            ctmr_pkg::ST_SEND: begin
                o_cmd.load_byte = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* sv/ctmr_dp.sv */
// Datapath with item register, per-channel state, message memory and output register.
module ctmr_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ctmr_pkg::t_cmd                     i_cmd,
    output ctmr_pkg::t_sts                     o_sts,
    input  logic [ctmr_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [ctmr_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                               o_m_tuser,
    output logic                               o_m_tlast
);

    logic                          r_op;
    logic [ctmr_pkg::CH_W-1:0]     r_arm_ch;
    logic [ctmr_pkg::CNT_W-1:0]    r_elen;
    logic [ctmr_pkg::TAG_W-1:0]    r_rtag;
    logic [ctmr_pkg::BYTE_W-1:0]   r_code;
    logic [ctmr_pkg::BYTE_W-1:0]   r_data;

    logic [ctmr_pkg::CNT_W-1:0]    r_alen  [ctmr_pkg::CHANNELS];
    logic [ctmr_pkg::TAG_W-1:0]    r_atag  [ctmr_pkg::CHANNELS];
    logic [ctmr_pkg::CNT_W-1:0]    r_bwant [ctmr_pkg::CHANNELS];
    logic [ctmr_pkg::TAG_W-1:0]    r_btag  [ctmr_pkg::CHANNELS];
    logic [ctmr_pkg::CNT_W-1:0]    r_bcnt  [ctmr_pkg::CHANNELS];

    logic [ctmr_pkg::BYTE_W-1:0]   r_mem [2**ctmr_pkg::MEM_AW];
    logic [ctmr_pkg::BYTE_W-1:0]   r_rd_data;

    logic [ctmr_pkg::CH_W-1:0]     r_ech;
    logic [ctmr_pkg::TAG_W-1:0]    r_etag;
    logic [ctmr_pkg::CNT_W-1:0]    r_n;
    logic [ctmr_pkg::CNT_W-1:0]    r_k;

    logic                          r_out_valid;
    logic                          r_out_status;
    logic [ctmr_pkg::CH_W-1:0]     r_out_ch;
    logic [ctmr_pkg::TAG_W-1:0]    r_out_tag;
    logic [ctmr_pkg::BYTE_W-1:0]   r_out_payload;
    logic                          r_out_last;

    logic                          code_ok;
    logic [ctmr_pkg::BYTE_W-1:0]   ch_full;
    logic [ctmr_pkg::CH_W-1:0]     ch;
    logic                          ch_ok;
    logic [ctmr_pkg::CH_AW-1:0]    cx;
    logic [ctmr_pkg::CH_AW-1:0]    ax;
    logic                          arm_ok;
    logic [ctmr_pkg::CNT_W-1:0]    alen_rd;
    logic [ctmr_pkg::TAG_W-1:0]    atag_rd;
    logic [ctmr_pkg::CNT_W-1:0]    bwant_rd;
    logic [ctmr_pkg::TAG_W-1:0]    btag_rd;
    logic [ctmr_pkg::CNT_W-1:0]    bcnt_rd;
    logic                          accept_byte;
    logic [ctmr_pkg::CNT_W-1:0]    n_cnt0;
    logic                          has_room;
    logic [ctmr_pkg::CNT_W-1:0]    n_cnt1;
    logic                          done;
    logic                          emit_last;
    logic                          out_free;

    assign code_ok  = (r_code >= ctmr_pkg::CODE_LO) && (r_code <= ctmr_pkg::CODE_HI);
    assign ch_full  = r_code - ctmr_pkg::CODE_LO;
    assign ch       = ch_full[ctmr_pkg::CH_W-1:0];
    assign ch_ok    = code_ok && (32'(ch) < ctmr_pkg::CHANNELS);
    assign cx       = ch[ctmr_pkg::CH_AW-1:0];
    assign ax       = r_arm_ch[ctmr_pkg::CH_AW-1:0];
    assign arm_ok   = 32'(r_arm_ch) < ctmr_pkg::CHANNELS;

    assign alen_rd  = ch_ok ? r_alen[cx]  : '0;
    assign atag_rd  = ch_ok ? r_atag[cx]  : '0;
    assign bwant_rd = ch_ok ? r_bwant[cx] : '0;
    assign btag_rd  = ch_ok ? r_btag[cx]  : '0;
    assign bcnt_rd  = ch_ok ? r_bcnt[cx]  : '0;

    assign accept_byte = (r_op == ctmr_pkg::OP_BYTE) && ch_ok && (alen_rd != '0);

    // A new request tag on a filling buffer starts it over.
    assign n_cnt0   = ((bwant_rd != '0) && (btag_rd != atag_rd)) ? '0 : bcnt_rd;
    assign has_room = n_cnt0 < ctmr_pkg::CNT_W'(ctmr_pkg::MAX_LEN);
    assign n_cnt1   = has_room ? n_cnt0 + ctmr_pkg::CNT_W'(1) : n_cnt0;
    assign done     = accept_byte && (n_cnt1 == alen_rd);

    assign emit_last = (r_k + ctmr_pkg::CNT_W'(1)) == r_n;
    assign out_free  = !r_out_valid || i_m_tready;

    assign o_sts.is_illegal = (r_op == ctmr_pkg::OP_BYTE) && !code_ok;
    assign o_sts.done       = done;
    assign o_sts.out_free   = out_free;
    assign o_sts.emit_last  = emit_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_s_tuser;
            r_arm_ch <= i_s_tdata[3:0];
            r_elen   <= i_s_tdata[10:4];
            r_rtag   <= i_s_tdata[26:11];
            r_code   <= i_s_tdata[34:27];
            r_data   <= i_s_tdata[42:35];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ctmr_pkg::CHANNELS; i++) begin
                r_alen[i]  <= '0;
                r_atag[i]  <= '0;
                r_bwant[i] <= '0;
                r_btag[i]  <= '0;
                r_bcnt[i]  <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_op == ctmr_pkg::OP_ARM) begin
                if (arm_ok) begin
                    r_alen[ax] <= r_elen;
                    r_atag[ax] <= r_rtag;
                end
            end else if (accept_byte) begin
                if (done) begin
                    r_alen[cx]  <= '0;
                    r_bwant[cx] <= '0;
                    r_btag[cx]  <= '0;
                    r_bcnt[cx]  <= '0;
                end else begin
                    r_bwant[cx] <= alen_rd;
                    r_btag[cx]  <= atag_rd;
                    r_bcnt[cx]  <= n_cnt1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && accept_byte && has_room) begin
            r_mem[{cx, n_cnt0[ctmr_pkg::LEN_W-1:0]}] <= r_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[{r_ech[ctmr_pkg::CH_AW-1:0], r_k[ctmr_pkg::LEN_W-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ech  <= ch;
            r_etag <= atag_rd;
            r_n    <= n_cnt1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.commit) begin
            r_k <= '0;
        end else if (i_cmd.load_byte) begin
            r_k <= r_k + ctmr_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_err || i_cmd.load_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_out_status  <= ctmr_pkg::STATUS_ERR;
            r_out_ch      <= '0;
            r_out_tag     <= '0;
            r_out_payload <= '0;
            r_out_last    <= 1'b1;
        end else if (i_cmd.load_byte) begin
            r_out_status  <= ctmr_pkg::STATUS_MSG;
            r_out_ch      <= r_ech;
            r_out_tag     <= r_etag;
            r_out_payload <= r_rd_data;
            r_out_last    <= emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_payload, r_out_tag, r_out_ch};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

/* sv/channel_tagged_message_reassembler_unit.sv */
// Top level of the channel-tagged message reassembler.
// The block takes one item at a time. An arm item, a dropped byte or a byte
// that does not finish a message passes the accept and execute states, in
// which the channel's state is read and updated. An illegal code waits in the
// execute state until the output register is free. A byte that completes a
// message of n bytes then passes a read and a send state for each byte, as
// each message byte is fetched through the single registered read port of the
// message memory and then loaded into the output register. The last result
// of a message can wait in the output register while the next item is taken.
module channel_tagged_message_reassembler_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // arm_channel, expect_len, request_tag, code_byte, data_byte, zero fill
    input  logic [ctmr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // channel, tag, payload, zero fill
    output logic [ctmr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    ctmr_pkg::t_cmd cmd;
    ctmr_pkg::t_sts sts;

    ctmr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_sts     (sts),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    ctmr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

/* sv/ctmr_chk.sv */
// Port-level checker for the reassembler and its bind to the top level.
module ctmr_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ctmr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser,
    input logic                           m_axis_tlast
);

    // A stalled result holds its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An error result is a single, otherwise empty item.
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ctmr_pkg::STATUS_ERR)
            |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("malformed error result");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted during execution");

    // Bytes of one message share channel and tag.
    a_msg_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(m_axis_tvalid && m_axis_tready && !m_axis_tlast
              && (m_axis_tuser == ctmr_pkg::STATUS_MSG)) && m_axis_tvalid
            |-> (m_axis_tuser == ctmr_pkg::STATUS_MSG)
                && (m_axis_tdata[19:0] == $past(m_axis_tdata[19:0])))
        else $error("message changed channel or tag");

endmodule

bind channel_tagged_message_reassembler_unit ctmr_chk u_ctmr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* sim/tb_channel_tagged_message_reassembler_unit.sv */
// Self-checking testbench for the message reassembler: directed table, then random traffic mixed with directed bursts.
module tb_channel_tagged_message_reassembler_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic                        op;
        logic [ctmr_pkg::CH_W-1:0]   arm_ch;
        logic [ctmr_pkg::CNT_W-1:0]  want_len;
        logic [ctmr_pkg::TAG_W-1:0]  req_tag;
        logic [ctmr_pkg::BYTE_W-1:0] code;
        logic [ctmr_pkg::BYTE_W-1:0] data;
    } t_link_item;

    typedef struct packed {
        logic                        status;
        logic [ctmr_pkg::CH_W-1:0]   channel;
        logic [ctmr_pkg::TAG_W-1:0]  tag;
        logic [ctmr_pkg::BYTE_W-1:0] payload;
        logic                        last;
    } t_msg_beat;

    typedef struct {
        t_link_item it;
        bit         typed;
        t_msg_beat  beat;
    } t_script_row;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // arm_channel, expect_len, request_tag, code_byte, data_byte, zero fill
    logic [ctmr_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    // opcode
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // channel, tag, payload, zero fill
    logic [ctmr_pkg::M_TDATA_W-1:0] m_axis_tdata;
    // status
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;

    channel_tagged_message_reassembler_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    logic [ctmr_pkg::CNT_W-1:0]  arm_len   [ctmr_pkg::CHANNELS];
    logic [ctmr_pkg::TAG_W-1:0]  arm_tag   [ctmr_pkg::CHANNELS];
    logic [ctmr_pkg::CNT_W-1:0]  fill_want [ctmr_pkg::CHANNELS];
    logic [ctmr_pkg::TAG_W-1:0]  fill_tag  [ctmr_pkg::CHANNELS];
    logic [ctmr_pkg::CNT_W-1:0]  fill_cnt  [ctmr_pkg::CHANNELS];
    logic [ctmr_pkg::BYTE_W-1:0] fill_bytes[ctmr_pkg::CHANNELS][ctmr_pkg::MAX_LEN];

    t_msg_beat   new_results[$];
    t_msg_beat   exp_results[$];
    t_script_row script[$];

    int unsigned cycle_cnt = 0;
    int unsigned err_count = 0;
    int unsigned n_items = 0;
    int unsigned n_arms = 0;
    int unsigned n_bytes = 0;
    int unsigned n_illegal = 0;
    int unsigned n_msgs = 0;
    int unsigned n_beats = 0;
    int          hold_left = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    bit          calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     exp_results.size());
            $display("tb_channel_tagged_message_reassembler_unit: errors");
            $finish;
        end
    end

    function automatic t_msg_beat make_beat(input logic st,
                                            input logic [ctmr_pkg::CH_W-1:0] ch,
                                            input logic [ctmr_pkg::TAG_W-1:0] tag,
                                            input logic [ctmr_pkg::BYTE_W-1:0] pl,
                                            input logic lst);
        t_msg_beat b;
        b.status = st;
        b.channel = ch;
        b.tag = tag;
        b.payload = pl;
        b.last = lst;
        return b;
    endfunction

    function automatic t_link_item mk_item(input logic op,
                                           input logic [ctmr_pkg::CH_W-1:0] ch,
                                           input logic [ctmr_pkg::CNT_W-1:0] len,
                                           input logic [ctmr_pkg::TAG_W-1:0] tag,
                                           input logic [ctmr_pkg::BYTE_W-1:0] code,
                                           input logic [ctmr_pkg::BYTE_W-1:0] data);
        t_link_item it;
        it.op = op;
        it.arm_ch = ch;
        it.want_len = len;
        it.req_tag = tag;
        it.code = code;
        it.data = data;
        return it;
    endfunction

    function automatic void add_row(input t_link_item it, input bit typed, input t_msg_beat b);
        t_script_row row;
        row.it = it;
        row.typed = typed;
        row.beat = b;
        script.push_back(row);
    endfunction

    // Applies one item to the channel state; returns 0 when the item was dropped.
    function automatic bit reassemble_item(input t_link_item it);
        logic [ctmr_pkg::CH_W-1:0] ch;
        int k;
        int n;
        new_results.delete();
        if (it.op == ctmr_pkg::OP_ARM) begin
            arm_len[it.arm_ch] = it.want_len;
            arm_tag[it.arm_ch] = it.req_tag;
            n_arms++;
            return 1'b1;
        end
        n_bytes++;
        if (it.code < ctmr_pkg::CODE_LO || it.code > ctmr_pkg::CODE_HI) begin
            new_results.push_back(make_beat(ctmr_pkg::STATUS_ERR, '0, '0, '0, 1'b1));
            n_illegal++;
            return 1'b1;
        end
        ch = ctmr_pkg::CH_W'(it.code - ctmr_pkg::CODE_LO);
        if (arm_len[ch] == 0)
            return 1'b0;
        if (fill_want[ch] != 0 && fill_tag[ch] != arm_tag[ch])
            fill_cnt[ch] = '0;
        fill_want[ch] = arm_len[ch];
        fill_tag[ch] = arm_tag[ch];
        if (fill_cnt[ch] < ctmr_pkg::MAX_LEN) begin
            fill_bytes[ch][fill_cnt[ch]] = it.data;
            fill_cnt[ch] = fill_cnt[ch] + 1'b1;
        end
        if (fill_cnt[ch] == fill_want[ch]) begin
            n = fill_cnt[ch];
            for (k = 0; k < n; k++)
                new_results.push_back(make_beat(ctmr_pkg::STATUS_MSG, ch, fill_tag[ch],
                                                fill_bytes[ch][k], k == n - 1));
            arm_len[ch] = '0;
            fill_want[ch] = '0;
            fill_tag[ch] = '0;
            fill_cnt[ch] = '0;
            n_msgs++;
        end
        return 1'b1;
    endfunction

    task automatic send_item(input t_link_item it, input bit typed, input t_msg_beat b,
                             output bit took);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 15)
                gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.op;
        s_axis_tdata <= {5'b0, it.data, it.code, it.req_tag, it.want_len, it.arm_ch};
        do @(posedge i_clk); while (!s_axis_tready);
        took = reassemble_item(it);
        if (typed)
            exp_results.push_back(b);
        else
            foreach (new_results[k])
                exp_results.push_back(new_results[k]);
        n_items++;
    endtask

    task automatic random_items(input int count);
        t_link_item it;
        int useful;
        int r;
        int lsel;
        int ch;
        int k;
        bit took;
        useful = 0;
        while (useful < count) begin
            it.arm_ch = ctmr_pkg::CH_W'($urandom);
            it.want_len = ctmr_pkg::CNT_W'($urandom);
            it.req_tag = ctmr_pkg::TAG_W'($urandom);
            it.code = ctmr_pkg::BYTE_W'($urandom);
            it.data = ctmr_pkg::BYTE_W'($urandom);
            r = $urandom_range(99);
            if (r < 25) begin
                it.op = ctmr_pkg::OP_ARM;
                lsel = $urandom_range(99);
                if (lsel < 8)
                    it.want_len = '0;
                else if (lsel < 88)
                    it.want_len = ctmr_pkg::CNT_W'($urandom_range(1, 6));
                else if (lsel < 96)
                    it.want_len = ctmr_pkg::CNT_W'($urandom_range(7, ctmr_pkg::MAX_LEN));
                else
                    it.want_len = ctmr_pkg::CNT_W'($urandom_range(ctmr_pkg::MAX_LEN + 1, 127));
                if ($urandom_range(1) == 1)
                    it.req_tag = arm_tag[it.arm_ch];
            end else begin
                it.op = ctmr_pkg::OP_BYTE;
                if (r < 85) begin
                    ch = $urandom_range(ctmr_pkg::CHANNELS - 1);
                    for (k = 0; k < ctmr_pkg::CHANNELS && arm_len[ch] == 0; k++)
                        ch = (ch + 1) % ctmr_pkg::CHANNELS;
                    it.code = ctmr_pkg::CODE_LO + ctmr_pkg::BYTE_W'(ch);
                end else if (r < 93) begin
                    if ($urandom_range(1) == 1)
                        it.code = ctmr_pkg::BYTE_W'($urandom_range(0, ctmr_pkg::CODE_LO - 1));
                    else
                        it.code = ctmr_pkg::BYTE_W'($urandom_range(ctmr_pkg::CODE_HI + 1, 255));
                end else begin
                    it.code = ctmr_pkg::CODE_LO
                              + ctmr_pkg::BYTE_W'($urandom_range(ctmr_pkg::CHANNELS - 1));
                end
            end
            send_item(it, 1'b0, '0, took);
            if (took)
                useful++;
        end
    endtask

    // Arms a channel (unless len is zero) and then feeds it nbytes random bytes.
    task automatic burst(input int ch, input logic [ctmr_pkg::CNT_W-1:0] len,
                         input logic [ctmr_pkg::TAG_W-1:0] tag, input int nbytes);
        t_link_item it;
        bit took;
        int k;
        it = mk_item(ctmr_pkg::OP_ARM, ctmr_pkg::CH_W'(ch), len, tag,
                     ctmr_pkg::BYTE_W'($urandom), ctmr_pkg::BYTE_W'($urandom));
        if (len != 0)
            send_item(it, 1'b0, '0, took);
        it.op = ctmr_pkg::OP_BYTE;
        it.code = ctmr_pkg::CODE_LO + ctmr_pkg::BYTE_W'(ch);
        for (k = 0; k < nbytes; k++) begin
            it.data = ctmr_pkg::BYTE_W'($urandom);
            send_item(it, 1'b0, '0, took);
        end
    endtask

    task automatic check_beat();
        t_msg_beat got;
        t_msg_beat want;
        got.status = m_axis_tuser;
        got.channel = m_axis_tdata[ctmr_pkg::CH_W-1:0];
        got.tag = m_axis_tdata[ctmr_pkg::CH_W+ctmr_pkg::TAG_W-1:ctmr_pkg::CH_W];
        got.payload = m_axis_tdata[ctmr_pkg::CH_W+ctmr_pkg::TAG_W+ctmr_pkg::BYTE_W-1:
                                   ctmr_pkg::CH_W+ctmr_pkg::TAG_W];
        got.last = m_axis_tlast;
        n_beats++;
        if (exp_results.size() == 0) begin
            err_count++;
            if (err_count <= 10)
                $display("Unexpected result: status %0d channel %0d tag %h payload %h last %0d",
                         got.status, got.channel, got.tag, got.payload, got.last);
            return;
        end
        want = exp_results.pop_front();
        if (got.status !== want.status || got.channel !== want.channel ||
            got.tag !== want.tag || got.payload !== want.payload || got.last !== want.last) begin
            err_count++;
            if (err_count <= 10) begin
                $display("Mismatch at cycle %0d:", cycle_cnt);
                $display("  expected status %0d channel %0d tag %h payload %h last %0d",
                         want.status, want.channel, want.tag, want.payload, want.last);
                $display("  actual   status %0d channel %0d tag %h payload %h last %0d",
                         got.status, got.channel, got.tag, got.payload, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_beat();
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 15);
            end
        end
    end

    initial begin
        int burst_ch;
        bit took;
        foreach (arm_len[c]) begin
            arm_len[c] = '0;
            arm_tag[c] = '0;
            fill_want[c] = '0;
            fill_tag[c] = '0;
            fill_cnt[c] = '0;
        end

        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO, 8'h55),
                1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'hF, 7'h7F, 16'hFFFF, 8'h00, 8'h00), 1'b1,
                make_beat(ctmr_pkg::STATUS_ERR, 4'd0, 16'h0000, 8'h00, 1'b1));
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO - 8'd1,
                        8'hA5), 1'b1,
                make_beat(ctmr_pkg::STATUS_ERR, 4'd0, 16'h0000, 8'h00, 1'b1));
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_HI + 8'd1,
                        8'h5A), 1'b1,
                make_beat(ctmr_pkg::STATUS_ERR, 4'd0, 16'h0000, 8'h00, 1'b1));
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, 8'hFF, 8'hFF), 1'b1,
                make_beat(ctmr_pkg::STATUS_ERR, 4'd0, 16'h0000, 8'h00, 1'b1));
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, 8'h80, 8'h01), 1'b1,
                make_beat(ctmr_pkg::STATUS_ERR, 4'd0, 16'h0000, 8'h00, 1'b1));
        add_row(mk_item(ctmr_pkg::OP_ARM, 4'hF, 7'd1, 16'hFFFF, 8'hFF, 8'hFF), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_HI, 8'hFF),
                1'b1, make_beat(ctmr_pkg::STATUS_MSG, 4'hF, 16'hFFFF, 8'hFF, 1'b1));
        add_row(mk_item(ctmr_pkg::OP_ARM, 4'd0, 7'd1, 16'h0000, 8'h00, 8'h00), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'hF, 7'h7F, 16'hFFFF, ctmr_pkg::CODE_LO, 8'h00),
                1'b1, make_beat(ctmr_pkg::STATUS_MSG, 4'd0, 16'h0000, 8'h00, 1'b1));
        // Two channels filling at once, completing in interleaved order.
        add_row(mk_item(ctmr_pkg::OP_ARM, 4'd3, 7'd3, 16'h1234, 8'h00, 8'h00), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO + 8'd3,
                        8'h11), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_ARM, 4'd4, 7'd2, 16'hAAAA, 8'h00, 8'h00), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO + 8'd4,
                        8'h22), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO + 8'd3,
                        8'h33), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO + 8'd4,
                        8'h44), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO + 8'd3,
                        8'h55), 1'b0, '0);
        // A new tag in the middle of a fill restarts the buffer.
        add_row(mk_item(ctmr_pkg::OP_ARM, 4'd5, 7'd3, 16'h0001, 8'h00, 8'h00), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO + 8'd5,
                        8'hA1), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_ARM, 4'd5, 7'd2, 16'h0002, 8'h00, 8'h00), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO + 8'd5,
                        8'hA2), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO + 8'd5,
                        8'hA3), 1'b0, '0);
        // A zero length disarms, so the byte that follows is dropped.
        add_row(mk_item(ctmr_pkg::OP_ARM, 4'd6, 7'd2, 16'h0007, 8'h00, 8'h00), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_ARM, 4'd6, 7'd0, 16'h0007, 8'h00, 8'h00), 1'b0, '0);
        add_row(mk_item(ctmr_pkg::OP_BYTE, 4'd0, 7'd0, 16'h0000, ctmr_pkg::CODE_LO + 8'd6,
                        8'h66), 1'b0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i])
            send_item(script[i].it, script[i].typed, script[i].beat, took);

        random_items(60);

        // Longest message; the receiver then stalls while the sender keeps going.
        burst_ch = $urandom_range(ctmr_pkg::CHANNELS - 1);
        burst(burst_ch, ctmr_pkg::CNT_W'(ctmr_pkg::MAX_LEN), ~fill_tag[burst_ch],
              ctmr_pkg::MAX_LEN - 1);
        hold_req <= 1'b1;
        burst(burst_ch, '0, '0, 1);
        calm <= 1'b1;
        random_items(50);
        calm <= 1'b0;

        // Overflow past the buffer, a re-arm with the same tag that stays stuck,
        // then a tag change that restarts and completes.
        burst_ch = $urandom_range(ctmr_pkg::CHANNELS - 1);
        burst(burst_ch, 7'd127, ~fill_tag[burst_ch], ctmr_pkg::MAX_LEN + 3);
        burst(burst_ch, 7'd2, arm_tag[burst_ch], 1);
        burst(burst_ch, 7'd2, ~arm_tag[burst_ch], 2);

        random_items(50);

        s_axis_tvalid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d arms, %0d byte pairs (%0d with illegal codes).",
                 n_items, n_arms, n_bytes, n_illegal);
        $display("Checked %0d result items from %0d completed messages, %0d failures.",
                 n_beats, n_msgs, err_count);
        if (err_count == 0)
            $display("tb_channel_tagged_message_reassembler_unit: clean");
        else
            $display("tb_channel_tagged_message_reassembler_unit: errors");
        $finish;
    end

endmodule

/* files.f */
sv/ctmr_pkg.sv
sv/ctmr_ctrl.sv
sv/ctmr_dp.sv
sv/channel_tagged_message_reassembler_unit.sv
sv/ctmr_chk.sv
sim/tb_channel_tagged_message_reassembler_unit.sv
